// ----- hw/rtl/bc13_pkg.sv -----
// bc13_pkg: shared types, constants and arithmetic helpers for the bc1/bc3 block decoder
// no dependencies; used by every module under hw/rtl

package bc13_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;

    // register widths and reset values
    localparam int                  WIDTH_W           = 13;
    localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RESET = 13'd4096;
    localparam int                  DEFAULT_MAX_DIM   = 4096;

    // decode modes
    localparam logic MODE_BC1 = 1'b0;
    localparam logic MODE_BC3 = 1'b1;

    // special alpha codes of the six-level palette
    localparam logic [2:0] ALPHA_CODE_ZERO = 3'd6;
    localparam logic [2:0] ALPHA_CODE_FULL = 3'd7;
    localparam logic [7:0] ALPHA_OPAQUE    = 8'hFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // one compressed block as it arrives
    typedef struct packed {
        logic [63:0] alpha_half;
        logic [63:0] color_half;
        logic [11:0] block_x;
        logic [11:0] block_y;
    } blk_t;

    // one decoded pixel as it leaves
    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] rgba;
        logic        inside_res;
        logic        last;
    } pix_t;

    // a classified block with its palettes, ready for pixel emission
    typedef struct packed {
        logic [3:0][23:0] col_pal;
        logic [7:0][7:0]  alpha_pal;
        logic [31:0]      col_idx;
        logic [47:0]      alpha_idx;
        logic [11:0]      block_x;
        logic [11:0]      block_y;
    } qent_t;

    // 5-bit channel to 8 bits with rounding
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [12:0] t;
        logic [12:0] s;
        t = 13'(v) * 13'd255 + 13'd16;
        s = (t >> 5) + t;
        return s[12:5];
    endfunction

    // 6-bit channel to 8 bits with rounding
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [13:0] t;
        logic [13:0] s;
        t = 14'(v) * 14'd255 + 14'd32;
        s = (t >> 6) + t;
        return s[13:6];
    endfunction

    // x / 3 for x below 1024 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    // alpha level for one 3-bit code
    function automatic logic [7:0] alpha_level(input logic [7:0] a0, input logic [7:0] a1,
                                               input logic [2:0] code);
        logic [3:0]  w0_7;
        logic [3:0]  w1;
        logic [3:0]  w0_5;
        logic [10:0] s7;
        logic [10:0] s5;
        logic [21:0] p7;
        logic [21:0] p5;
        logic [7:0]  r;
        w0_7 = 4'd8 - {1'b0, code};
        w1   = {1'b0, code} - 4'd1;
        w0_5 = 4'd6 - {1'b0, code};
        s7 = 11'(w0_7) * 11'(a0) + 11'(w1) * 11'(a1);
        s5 = 11'(w0_5) * 11'(a0) + 11'(w1) * 11'(a1);
        // divide by 7 and by 5 through reciprocals
        p7 = 22'(s7) * 22'd2341;
        p5 = 22'(s5) * 22'd3277;
        if (code == 3'd0)
            r = a0;
        else if (code == 3'd1)
            r = a1;
        else if (a0 > a1)
            r = p7[21:14];
        else if (code == ALPHA_CODE_ZERO)
            r = 8'd0;
        else if (code == ALPHA_CODE_FULL)
            r = ALPHA_OPAQUE;
        else
            r = p5[21:14];
        return r;
    endfunction

endpackage

// ----- hw/rtl/bc13_front.sv -----
// bc13_front: accepts compressed blocks, widens endpoints and builds colour and alpha palettes
// depends on bc13_pkg

module bc13_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode,
    input  logic              blk_valid,
    output logic              blk_ready,
    input  bc13_pkg::blk_t    blk,
    output logic              push_valid,
    input  logic              push_ready,
    output bc13_pkg::qent_t   push_data
);

    // stage a: raw block
    logic            a_valid_reg;
    bc13_pkg::blk_t  a_blk_reg;
    logic            a_mode_reg;

    // stage b: widened endpoints
    logic            b_valid_reg;
    logic [2:0][7:0] b_e0_reg;
    logic [2:0][7:0] b_e1_reg;
    logic            b_four_reg;
    logic            b_mode_reg;
    logic [7:0]      b_a0_reg;
    logic [7:0]      b_a1_reg;
    logic [31:0]     b_col_idx_reg;
    logic [47:0]     b_alpha_idx_reg;
    logic [11:0]     b_x_reg;
    logic [11:0]     b_y_reg;

    logic            b_ready;
    logic            a_adv;
    logic [15:0]     c0;
    logic [15:0]     c1;
    logic [2:0][7:0] e0_next;
    logic [2:0][7:0] e1_next;
    logic            four_next;

    assign b_ready    = !b_valid_reg || push_ready;
    assign a_adv      = a_valid_reg && b_ready;
    assign blk_ready  = !a_valid_reg || b_ready;
    assign push_valid = b_valid_reg;

    // endpoint expansion from rgb565
    always_comb
    begin
        c0 = a_blk_reg.color_half[15:0];
        c1 = a_blk_reg.color_half[31:16];
        e0_next[0] = bc13_pkg::widen5(c0[15:11]);
        e0_next[1] = bc13_pkg::widen6(c0[10:5]);
        e0_next[2] = bc13_pkg::widen5(c0[4:0]);
        e1_next[0] = bc13_pkg::widen5(c1[15:11]);
        e1_next[1] = bc13_pkg::widen6(c1[10:5]);
        e1_next[2] = bc13_pkg::widen5(c1[4:0]);
        four_next  = (a_mode_reg == bc13_pkg::MODE_BC3) || (c0 > c1);
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (blk_ready)
                a_valid_reg <= blk_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (blk_valid && blk_ready)
        begin
            a_blk_reg  <= blk;
            a_mode_reg <= mode;
        end
        if (a_adv)
        begin
            b_e0_reg        <= e0_next;
            b_e1_reg        <= e1_next;
            b_four_reg      <= four_next;
            b_mode_reg      <= a_mode_reg;
            b_a0_reg        <= a_blk_reg.alpha_half[7:0];
            b_a1_reg        <= a_blk_reg.alpha_half[15:8];
            b_col_idx_reg   <= a_blk_reg.color_half[63:32];
            b_alpha_idx_reg <= a_blk_reg.alpha_half[63:16];
            b_x_reg         <= a_blk_reg.block_x;
            b_y_reg         <= a_blk_reg.block_y;
        end
    end

    // palette construction
    always_comb
    begin
        logic [9:0] s2;
        logic [9:0] s3;
        logic [8:0] sm;
        push_data = '0;
        for (int k = 0; k < 3; k++)
        begin
            s2 = 10'({b_e0_reg[k], 1'b0}) + 10'(b_e1_reg[k]);
            s3 = 10'(b_e0_reg[k]) + 10'({b_e1_reg[k], 1'b0});
            sm = 9'(b_e0_reg[k]) + 9'(b_e1_reg[k]);
            push_data.col_pal[0][23-8*k -: 8] = b_e0_reg[k];
            push_data.col_pal[1][23-8*k -: 8] = b_e1_reg[k];
            if (b_four_reg)
            begin
                push_data.col_pal[2][23-8*k -: 8] = bc13_pkg::div3(s2);
                push_data.col_pal[3][23-8*k -: 8] = bc13_pkg::div3(s3);
            end
            else
            begin
                push_data.col_pal[2][23-8*k -: 8] = sm[8:1];
                push_data.col_pal[3][23-8*k -: 8] = 8'd0;
            end
        end
        // bc1 alpha is always opaque
        for (int c = 0; c < 8; c++)
        begin
            if (b_mode_reg == bc13_pkg::MODE_BC3)
                push_data.alpha_pal[c] = bc13_pkg::alpha_level(b_a0_reg, b_a1_reg, 3'(c));
            else
                push_data.alpha_pal[c] = bc13_pkg::ALPHA_OPAQUE;
        end
        push_data.col_idx   = b_col_idx_reg;
        push_data.alpha_idx = b_alpha_idx_reg;
        push_data.block_x   = b_x_reg;
        push_data.block_y   = b_y_reg;
    end

endmodule

// ----- hw/rtl/bc13_queue.sv -----
// bc13_queue: short register queue decoupling the front from the pixel emitter
// depends on bc13_pkg

module bc13_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  bc13_pkg::qent_t   push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output bc13_pkg::qent_t   pop_data
);

    bc13_pkg::qent_t               mem_reg [bc13_pkg::QUEUE_DEPTH];
    logic [bc13_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [bc13_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [bc13_pkg::QPTR_W:0]     count_reg;
    logic [bc13_pkg::QPTR_W:0]     count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (count_reg != (bc13_pkg::QPTR_W+1)'(bc13_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- hw/rtl/bc13_back.sv -----
// bc13_back: walks a classified block and emits its sixteen pixels through an output register
// depends on bc13_pkg

module bc13_back #(
    parameter int MAX_DIM = bc13_pkg::DEFAULT_MAX_DIM
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bc13_pkg::WIDTH_W-1:0]  image_width,
    input  logic                          pop_valid,
    output logic                          pop_ready,
    input  bc13_pkg::qent_t               pop_data,
    output logic                          pix_valid,
    input  logic                          pix_ready,
    output bc13_pkg::pix_t                pix
);

    localparam int DimW = $clog2(MAX_DIM + 1);
    localparam int CmpW = (DimW > bc13_pkg::WIDTH_W) ? DimW : bc13_pkg::WIDTH_W;

    bc13_pkg::qent_t  cur_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [3:0]       cnt_reg;
    logic [3:0]       cnt_next;
    logic             pix_valid_reg;
    bc13_pkg::pix_t   pix_reg;
    bc13_pkg::pix_t   pix_next;
    logic             issue;
    logic             load;
    logic             at_end;
    logic [CmpW-1:0]  eff_width;
    logic [CmpW-1:0]  img_ext;
    logic [CmpW-1:0]  max_ext;

    // effective clipping width
    assign img_ext   = CmpW'(image_width);
    assign max_ext   = CmpW'(MAX_DIM);
    assign eff_width = (img_ext > max_ext) ? max_ext : img_ext;

    // issue and refill control
    assign at_end    = (cnt_reg == 4'd15);
    assign issue     = busy_reg && (!pix_valid_reg || pix_ready);
    assign load      = pop_valid && (!busy_reg || (issue && at_end));
    assign pop_ready = load;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (at_end)
                busy_next = 1'b0;
        end
    end

    // pixel for the current position
    always_comb
    begin
        logic [1:0]  ci;
        logic [2:0]  ac;
        logic [12:0] sx;
        ci = cur_reg.col_idx[{cnt_reg, 1'b0} +: 2];
        ac = cur_reg.alpha_idx[6'(cnt_reg) * 6'd3 +: 3];
        sx = 13'(cur_reg.block_x) + 13'(cnt_reg[1:0]);
        pix_next.pixel_x    = sx[11:0];
        pix_next.pixel_y    = cur_reg.block_y + 12'(cnt_reg[3:2]);
        pix_next.rgba       = {cur_reg.col_pal[ci], cur_reg.alpha_pal[ac]};
        pix_next.inside_res = (CmpW'(sx) < eff_width);
        pix_next.last       = at_end;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 4'd0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (issue)
                pix_valid_reg <= 1'b1;
            else if (pix_ready)
                pix_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= pop_data;
        if (issue)
            pix_reg <= pix_next;
    end

endmodule

// ----- hw/rtl/bc1_bc3_texture_block_decoder.sv -----
// bc1_bc3_texture_block_decoder: top level of the bc1/bc3 4x4 block decoder
// depends on bc13_pkg, bc13_front, bc13_queue, bc13_back
//
// usage
// - blk channel (blk_valid/blk_ready/blk) takes one compressed 4x4 block and its
//   top-left coordinates per request
// - pix channel (pix_valid/pix_ready/pix) returns sixteen pixels per block in
//   row-major order, last set on the sixteenth
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes mode and image
//   width; cfg_ready is always high, writes are meant for idle periods only
// - the first pixel of a block passes through the two front stages, the queue,
//   the current-block register of the back end and the output register
// - throughput: one pixel per cycle while pix_ready is high, set by the single
//   pixel emitter in the back end; blocks follow each other with no gap
// - a two-entry queue lets the front keep taking requests while the emitter
//   works through a block
// - reset: mode returns to bc1, image width to 4096, all pipelines empty
// - when the receiver holds pix_ready low the output register keeps its pixel,
//   the emitter stops and the queue and front fill up before blk_ready drops

module bc1_bc3_texture_block_decoder #(
    parameter int MAX_DIM = bc13_pkg::DEFAULT_MAX_DIM
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bc13_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bc13_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            blk_valid,
    output logic                            blk_ready,
    input  bc13_pkg::blk_t                  blk,
    output logic                            pix_valid,
    input  logic                            pix_ready,
    output bc13_pkg::pix_t                  pix
);

    logic                          mode_reg;
    logic [bc13_pkg::WIDTH_W-1:0]  image_width_reg;
    logic                          push_valid;
    logic                          push_ready;
    bc13_pkg::qent_t               push_data;
    logic                          pop_valid;
    logic                          pop_ready;
    bc13_pkg::qent_t               pop_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= bc13_pkg::MODE_BC1;
            image_width_reg <= bc13_pkg::IMAGE_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bc13_pkg::REG_MODE:        mode_reg <= cfg_data[0];
                bc13_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // block classification and palette build
    bc13_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .blk_valid  (blk_valid),
        .blk_ready  (blk_ready),
        .blk        (blk),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    bc13_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // pixel emission
    bc13_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .image_width (image_width_reg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix)
    );

endmodule
